// File: src/qvcp_pkg.sv
// ----------------------------------------------------------------------------
// qvcp_pkg
// Shared widths, parameter defaults and register reset values of the queued
// voice clip player.
// ----------------------------------------------------------------------------
`default_nettype none

package qvcp_pkg;

  // Field widths fixed by the command and result formats.
  localparam int CMD_W      = 2;
  localparam int CLIP_W     = 4;
  localparam int ADDR_W     = 16;
  localparam int LEN_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int SAMPLE_W   = 16;
  localparam int FACTOR_W   = 4;
  localparam int GAP_W      = 16;
  localparam int BLOCK_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Default sizes of the queue, the clip table and the sample memory.
  localparam int DEF_QUEUE_DEPTH  = 16;
  localparam int DEF_NUM_CLIPS    = 16;
  localparam int DEF_SAMPLE_DEPTH = 65536;

  // Register values after reset.
  localparam logic [FACTOR_W-1:0] RESAMPLE_RST = FACTOR_W'(6);
  localparam logic [GAP_W-1:0]    GAP_RST      = GAP_W'(24000);
  localparam logic [BLOCK_W-1:0]  BLOCK_RST    = BLOCK_W'(240);

endpackage

`default_nettype wire

// File: src/qvcp_ram.sv
// ----------------------------------------------------------------------------
// qvcp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module qvcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: src/qvcp_addr_mod.sv
// ----------------------------------------------------------------------------
// qvcp_addr_mod
// Reduces a 16-bit sample address modulo the sample memory depth. A
// two-stage pipeline: the quotient comes from a multiply by the reciprocal,
// the remainder is corrected by at most one subtraction on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module qvcp_addr_mod
  import qvcp_pkg::*;
#(
  parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
) (
  input  wire                            clk_i,
  input  wire [ADDR_W-1:0]               addr_i,
  output logic [$clog2(SAMPLE_DEPTH)-1:0] index_o
);

  localparam int          IDX_W   = $clog2(SAMPLE_DEPTH);
  localparam logic [32:0] RECIP   = 33'((64'd1 << 32) / SAMPLE_DEPTH);
  localparam logic [24:0] DEPTH_C = 25'(SAMPLE_DEPTH);

  logic [48:0]       prod;
  logic [40:0]       quot_x_depth;
  logic [ADDR_W-1:0] quot_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W:0]   rem_q;
  logic [24:0]       rem_ext;
  logic [24:0]       rem_fix;

  // The estimated quotient is at most one below the true one, so the
  // remainder stays below twice the depth.
  assign prod         = 49'(addr_i) * 49'(RECIP);
  assign quot_x_depth = 41'(quot_q) * 41'(DEPTH_C);

  always_ff @(posedge clk_i) begin
    quot_q <= prod[47:32];
    addr_q <= addr_i;
    rem_q  <= 17'(addr_q) - quot_x_depth[ADDR_W:0];
  end

  assign rem_ext = 25'(rem_q);
  assign rem_fix = (rem_ext >= DEPTH_C) ? rem_ext - DEPTH_C : rem_ext;
  assign index_o = rem_fix[IDX_W-1:0];

endmodule

`default_nettype wire

// File: src/queued_voice_clip_player.sv
// ----------------------------------------------------------------------------
// queued_voice_clip_player
// Voice prompt player: a ring queue of clip numbers, a clip table and a byte
// sample memory, all in synchronous RAM, run by one command sequencer.
// ----------------------------------------------------------------------------
// One command is taken when start is high and busy is low. Its single result
// is shown for exactly one cycle with done_o high and must be captured then;
// the block cannot be held off. Clip entry writes, refused enqueues and
// enqueues while a clip or a gap is playing return their result in the cycle
// after the start. A sample byte write passes the two-stage address reduction
// and then the write step. A tick passes the frame step and, when it plays a
// sample, the address reduction, the registered sample memory read and the
// output step. Loading a clip, at a block start after the gap or on an enqueue
// while stopped, adds a queue read, a clip table read and a load step for
// every queue entry popped, and a last queue check when the queue runs empty
// without a valid clip. Where busy rises, it drops in the cycle that shows the
// result, so the next command can be taken at the edge of the result transfer.
// Configuration writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module queued_voice_clip_player
  import qvcp_pkg::*;
#(
  parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
  parameter int NUM_CLIPS    = DEF_NUM_CLIPS,
  parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start,
  output logic                              busy,
  input  wire [CMD_W-1:0]                   cmd_i,
  input  wire [CLIP_W-1:0]                  clip_number_i,
  input  wire [ADDR_W-1:0]                  mem_address_i,
  input  wire [LEN_W-1:0]                   clip_length_in_i,
  input  wire                               clip_valid_in_i,
  input  wire [BYTE_W-1:0]                  sample_byte_i,
  output logic                              done_o,
  output logic signed [SAMPLE_W-1:0]        audio_sample_o,
  output logic                              accepted_o,
  output logic                              busy_res_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]  queued_o,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire [CFG_IDX_W-1:0]               cfg_index_i,
  input  wire [CFG_DATA_W-1:0]              cfg_data_i
);

  localparam int QI_W = $clog2(QUEUE_DEPTH);
  localparam int QF_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CI_W = $clog2(NUM_CLIPS);
  localparam int SA_W = $clog2(SAMPLE_DEPTH);

  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLIP   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_RESAMPLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK    = 2'd2;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_PLAYING = 2'd1,
    MODE_GAP     = 2'd2
  } mode_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FRAME = 9'b000000010,
    S_LDQ   = 9'b000000100,
    S_LDT   = 9'b000001000,
    S_LDC   = 9'b000010000,
    S_MODW  = 9'b000100000,
    S_SWR   = 9'b001000000,
    S_SRD   = 9'b010000000,
    S_SOUT  = 9'b100000000
  } state_e;

  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [QI_W-1:0]     head_q, head_d;
  logic [QI_W-1:0]     tail_q, tail_d;
  logic [QF_W-1:0]     fill_q, fill_d;
  logic [ADDR_W-1:0]   cstart_q, cstart_d;
  logic [LEN_W-1:0]    clen_q, clen_d;
  logic [LEN_W-1:0]    src_q, src_d;
  logic [FACTOR_W-1:0] rep_q, rep_d;
  logic [GAP_W-1:0]    gap_q, gap_d;
  logic [BLOCK_W-1:0]  phase_q, phase_d;
  logic [NUM_CLIPS-1:0] vbit_q;
  logic                from_push_q, from_push_d;
  logic                clip_ok_q, clip_ok_d;
  logic                mod_wr_q, mod_wr_d;
  logic                wait_q, wait_d;
  logic [ADDR_W-1:0]   mod_addr_q, mod_addr_d;
  logic [BYTE_W-1:0]   byte_q, byte_d;

  logic [FACTOR_W-1:0] resample_q;
  logic [GAP_W-1:0]    gap_cfg_q;
  logic [BLOCK_W-1:0]  block_cfg_q;

  logic                done_q;
  logic [SAMPLE_W-1:0] audio_q;
  logic                acc_q;
  logic                bres_q;
  logic [QF_W-1:0]     queued_q;

  logic                fin;
  logic [SAMPLE_W-1:0] fin_sample;
  logic                fin_acc;
  logic                q_we;
  logic                t_we;
  logic                s_we;
  logic                clip_in_range;

  logic [CLIP_W-1:0]        q_rdata;
  logic [ADDR_W+LEN_W-1:0]  t_rdata;
  logic [BYTE_W-1:0]        s_rdata;
  logic [SA_W-1:0]          s_idx;

  logic [FACTOR_W-1:0] factor;
  logic [BLOCK_W-1:0]  blk;
  logic [BLOCK_W:0]    phase_inc;
  logic [FACTOR_W:0]   rep_inc;

  assign clip_in_range = 9'(clip_number_i) < 9'(NUM_CLIPS);
  assign factor        = (resample_q == '0) ? FACTOR_W'(1) : resample_q;
  assign blk           = (block_cfg_q == '0) ? BLOCK_W'(1) : block_cfg_q;
  assign phase_inc     = {1'b0, phase_q} + 1'b1;
  assign rep_inc       = {1'b0, rep_q} + 1'b1;

  // Storage. Writes happen only when a command is taken or in the sample
  // write step, and reads of the same entry always fall in later cycles, so
  // no forwarding is needed.
  qvcp_ram #(
    .WIDTH(CLIP_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(tail_q),
    .wdata_i(clip_number_i),
    .raddr_i(head_q),
    .rdata_o(q_rdata)
  );

  qvcp_ram #(
    .WIDTH(ADDR_W + LEN_W),
    .DEPTH(NUM_CLIPS)
  ) u_clip_ram (
    .clk_i  (clk_i),
    .we_i   (t_we),
    .waddr_i(CI_W'(clip_number_i)),
    .wdata_i({mem_address_i, clip_length_in_i}),
    .raddr_i(CI_W'(q_rdata)),
    .rdata_o(t_rdata)
  );

  qvcp_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(SAMPLE_DEPTH)
  ) u_sample_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_idx),
    .wdata_i(byte_q),
    .raddr_i(s_idx),
    .rdata_o(s_rdata)
  );

  qvcp_addr_mod #(
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_addr_mod (
    .clk_i  (clk_i),
    .addr_i (mod_addr_q),
    .index_o(s_idx)
  );

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    cstart_d    = cstart_q;
    clen_d      = clen_q;
    src_d       = src_q;
    rep_d       = rep_q;
    gap_d       = gap_q;
    phase_d     = phase_q;
    from_push_d = from_push_q;
    clip_ok_d   = clip_ok_q;
    mod_wr_d    = mod_wr_q;
    wait_d      = wait_q;
    mod_addr_d  = mod_addr_q;
    byte_d      = byte_q;
    fin         = 1'b0;
    fin_sample  = '0;
    fin_acc     = 1'b0;
    q_we        = 1'b0;
    t_we        = 1'b0;
    s_we        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (cmd_i)
            CMD_TICK: begin
              from_push_d = 1'b0;
              if (phase_q == '0 && mode_q == MODE_GAP && gap_q == '0) begin
                state_d = S_LDQ;
              end else begin
                state_d = S_FRAME;
              end
            end
            CMD_PUSH: begin
              if (fill_q < QF_W'(QUEUE_DEPTH)) begin
                q_we   = 1'b1;
                tail_d = (tail_q == QI_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
                fill_d = fill_q + 1'b1;
                if (mode_q == MODE_STOPPED) begin
                  from_push_d = 1'b1;
                  state_d     = S_LDQ;
                end else begin
                  fin     = 1'b1;
                  fin_acc = 1'b1;
                end
              end else begin
                fin = 1'b1;
              end
            end
            CMD_CLIP: begin
              t_we = clip_in_range;
              fin  = 1'b1;
            end
            CMD_SAMPLE: begin
              mod_addr_d = mem_address_i;
              byte_d     = sample_byte_i;
              mod_wr_d   = 1'b1;
              wait_d     = 1'b0;
              state_d    = S_MODW;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_LDQ: begin
        if (fill_q == '0) begin
          // Nothing left to play.
          if (from_push_q) begin
            fin     = 1'b1;
            fin_acc = 1'b1;
            state_d = S_IDLE;
          end else begin
            mode_d   = MODE_STOPPED;
            cstart_d = '0;
            clen_d   = '0;
            src_d    = '0;
            rep_d    = '0;
            state_d  = S_FRAME;
          end
        end else begin
          head_d  = (head_q == QI_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
          fill_d  = fill_q - 1'b1;
          state_d = S_LDT;
        end
      end

      S_LDT: begin
        clip_ok_d = (9'(q_rdata) < 9'(NUM_CLIPS)) && vbit_q[CI_W'(q_rdata)];
        state_d   = S_LDC;
      end

      S_LDC: begin
        if (clip_ok_q) begin
          cstart_d = t_rdata[ADDR_W+LEN_W-1:LEN_W];
          clen_d   = t_rdata[LEN_W-1:0];
          src_d    = '0;
          rep_d    = '0;
          gap_d    = '0;
          mode_d   = MODE_PLAYING;
          if (from_push_q) begin
            phase_d = '0;
            fin     = 1'b1;
            fin_acc = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_FRAME;
          end
        end else begin
          // Invalid entries are dropped and the next one is tried.
          state_d = S_LDQ;
        end
      end

      S_FRAME: begin
        phase_d = (phase_inc >= {1'b0, blk}) ? '0 : phase_inc[BLOCK_W-1:0];
        state_d = S_IDLE;
        case (mode_q)
          MODE_PLAYING: begin
            if (src_q < clen_q) begin
              mod_addr_d = cstart_q + src_q;
              mod_wr_d   = 1'b0;
              wait_d     = 1'b0;
              state_d    = S_MODW;
              if (rep_inc >= {1'b0, factor}) begin
                rep_d = '0;
                src_d = src_q + 1'b1;
              end else begin
                rep_d = rep_inc[FACTOR_W-1:0];
              end
            end else begin
              gap_d  = gap_cfg_q;
              mode_d = MODE_GAP;
              fin    = 1'b1;
            end
          end
          MODE_GAP: begin
            if (gap_q != '0) begin
              gap_d = gap_q - 1'b1;
            end
            fin = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_MODW: begin
        // Wait out the address reduction pipeline.
        wait_d = 1'b1;
        if (wait_q) begin
          state_d = mod_wr_q ? S_SWR : S_SRD;
        end
      end

      S_SWR: begin
        s_we    = 1'b1;
        fin     = 1'b1;
        state_d = S_IDLE;
      end

      S_SRD: begin
        state_d = S_SOUT;
      end

      S_SOUT: begin
        fin_sample = {s_rdata ^ 8'h80, 8'h00};
        fin        = 1'b1;
        state_d    = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_STOPPED;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      cstart_q    <= '0;
      clen_q      <= '0;
      src_q       <= '0;
      rep_q       <= '0;
      gap_q       <= '0;
      phase_q     <= '0;
      vbit_q      <= '0;
      from_push_q <= 1'b0;
      clip_ok_q   <= 1'b0;
      mod_wr_q    <= 1'b0;
      wait_q      <= 1'b0;
      done_q      <= 1'b0;
      resample_q  <= RESAMPLE_RST;
      gap_cfg_q   <= GAP_RST;
      block_cfg_q <= BLOCK_RST;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      cstart_q    <= cstart_d;
      clen_q      <= clen_d;
      src_q       <= src_d;
      rep_q       <= rep_d;
      gap_q       <= gap_d;
      phase_q     <= phase_d;
      from_push_q <= from_push_d;
      clip_ok_q   <= clip_ok_d;
      mod_wr_q    <= mod_wr_d;
      wait_q      <= wait_d;
      done_q      <= fin;
      if (t_we) begin
        vbit_q[CI_W'(clip_number_i)] <= clip_valid_in_i;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_RESAMPLE: resample_q  <= cfg_data_i[FACTOR_W-1:0];
          CFG_GAP:      gap_cfg_q   <= cfg_data_i[GAP_W-1:0];
          CFG_BLOCK:    block_cfg_q <= cfg_data_i[BLOCK_W-1:0];
          default:      ;
        endcase
      end
    end
  end

  // Result and operand registers carry no reset.
  always_ff @(posedge clk_i) begin
    mod_addr_q <= mod_addr_d;
    byte_q     <= byte_d;
    if (fin) begin
      audio_q  <= fin_sample;
      acc_q    <= fin_acc;
      bres_q   <= (mode_d != MODE_STOPPED) || (fill_d != '0);
      queued_q <= fill_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign audio_sample_o = audio_q;
  assign accepted_o     = acc_q;
  assign busy_res_o     = bres_q;
  assign queued_o       = queued_q;
  assign cfg_ready_o    = 1'b1;

`ifndef NO_ASSERTIONS
  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start && cmd_i == CMD_PUSH && fill_q < QF_W'(QUEUE_DEPTH))
    |=> (fill_q == $past(fill_q) + 1'b1))
    else $error("taken enqueue did not raise the queue fill");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (head_q == tail_q))
    else $error("queue is empty but head and tail differ");

  a_frame_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FRAME) |-> !(phase_q == '0 && mode_q == MODE_GAP && gap_q == '0))
    else $error("frame made at a block start without loading the next clip");
`endif

endmodule

`default_nettype wire
